/* sv/lbs_pkg.sv */
// Shared constants, types and a helper function of the vertex skinning block.
package lbs_pkg;

  localparam int MAX_BONES = 64;
  localparam int FRAC_BITS = 16;
  localparam int ELEMS     = 12;
  localparam int ELEM_W    = 4;
  localparam int SLOT_W    = 6;
  localparam int ADDR_W    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int BONE_W    = 7;
  localparam int WGT_W     = 10;
  localparam int WMAX      = 255;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 66;
  localparam int T_W       = SUM_W - FRAC_BITS;
  localparam int WP_W      = T_W + WGT_W;
  localparam int ACC_W     = WP_W + 2;
  localparam int R_W       = 12;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int IN_DATA_W = 200;
  localparam int OUT_DATA_W = 96;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SKIN = 1'b1;
  localparam logic CFG_BPV  = 1'b0;
  localparam logic CFG_BCNT = 1'b1;

  typedef struct packed {
    logic                    skin;
    logic [SLOT_W-1:0]       slot;
    logic [ELEM_W-1:0]       elem;
    logic [31:0]             value;
    logic [2:0][31:0]        pos;
    logic [3:0][BONE_W-1:0]  bone;
    logic [3:0][WGT_W-1:0]   wgt;
    logic [1:0]              last_k;
    logic                    bad;
  } item_t;

  // Stored bone bytes hold three times the bone number; 171/512 divides by three
  // exactly for every byte value.
  function automatic logic [BONE_W-1:0] div3(input logic [7:0] b);
    logic [15:0] p;
    p = 16'(b) * 16'd171;
    return p[15:9];
  endfunction

endpackage

/* sv/lbs_fifo.sv */
// Short item queue between the front and back parts.
module lbs_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lbs_pkg::item_t push_item,
  output logic          full,
  input  logic          pop,
  output lbs_pkg::item_t head,
  output logic          empty
);
  import lbs_pkg::*;

  item_t                 q [QDEPTH];
  logic [QPTR_W-1:0]     wptr;
  logic [QPTR_W-1:0]     rptr;
  logic [QPTR_W:0]       count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = q[rptr];

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* sv/lbs_front.sv */
// Front part: takes input beats and configuration, decodes bones, weights and the bad flag.
module lbs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lbs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [6:0]                        cfg_data,
  output logic                              push,
  output lbs_pkg::item_t                    push_item,
  input  logic                              q_full
);
  import lbs_pkg::*;

  logic [2:0]             bones_per_vertex;
  logic [6:0]             bone_count;
  logic [2:0]             n;
  logic [2:0][7:0]        wb;
  logic [3:0][BONE_W-1:0] bone;
  logic [3:0][WGT_W-1:0]  w;
  logic                   bad;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      bones_per_vertex <= 3'd4;
      bone_count       <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BPV:  bones_per_vertex <= cfg_data[2:0];
        CFG_BCNT: bone_count       <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (bones_per_vertex == 3'd0) n = 3'd1;
    else if (bones_per_vertex > 3'd4) n = 3'd4;
    else n = bones_per_vertex;

    for (int k = 0; k < 3; k++)
      wb[k] = s_axis_tdata[170 + 8*k +: 8];
    for (int k = 0; k < 4; k++)
      bone[k] = div3(s_axis_tdata[138 + 8*k +: 8]);

    w = '0;
    case (n)
      3'd1: w[0] = WGT_W'(WMAX);
      3'd2: begin
        w[0] = WGT_W'(WMAX) - WGT_W'(wb[0]);
        w[1] = WGT_W'(wb[0]);
      end
      3'd3: begin
        w[0] = WGT_W'(wb[0]);
        w[1] = WGT_W'(wb[1]);
        w[2] = WGT_W'(WMAX) - WGT_W'(wb[0]) - WGT_W'(wb[1]);
      end
      default: begin
        w[0] = WGT_W'(wb[0]);
        w[1] = WGT_W'(wb[1]);
        w[2] = WGT_W'(wb[2]);
        w[3] = WGT_W'(WMAX) - WGT_W'(wb[0]) - WGT_W'(wb[1]) - WGT_W'(wb[2]);
      end
    endcase

    bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n && (bone[k] >= bone_count || bone[k] >= BONE_W'(MAX_BONES)))
        bad = 1'b1;
    end

    push_item.skin   = (s_axis_tuser == CMD_SKIN);
    push_item.slot   = s_axis_tdata[5:0];
    push_item.elem   = s_axis_tdata[9:6];
    push_item.value  = s_axis_tdata[41:10];
    push_item.pos[0] = s_axis_tdata[73:42];
    push_item.pos[1] = s_axis_tdata[105:74];
    push_item.pos[2] = s_axis_tdata[137:106];
    push_item.bone   = bone;
    push_item.wgt    = w;
    push_item.last_k = 2'(n - 3'd1);
    push_item.bad    = bad;
  end

endmodule

/* sv/lbs_div255.sv */
// Pipelined signed divide by 255 with round to nearest and saturation to 32 bits.
module lbs_div255 (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [lbs_pkg::ACC_W-1:0]  acc,
  output logic signed [31:0]                res
);
  import lbs_pkg::*;

  localparam int NT = (ACC_W - 1) / 8;
  localparam int NA = NT / 2;

  logic [ACC_W-1:0]  x1, x2, x3;
  logic              neg1, neg2, neg3, neg4;
  logic [ACC_W-1:0]  pa, pb, pa_next, pb_next, q3, q4;
  logic [R_W-1:0]    r4;
  logic [ACC_W-1:0]  r_full;
  logic [R_W+9:0]    corr_p;
  logic [ACC_W-1:0]  q;
  logic signed [ACC_W-1:0] sq;

  // The truncated series x/256 + x/65536 + ... falls short of x/255 by less
  // than eight, so the remainder left over stays below 4096.
  always_comb begin
    pa_next = '0;
    pb_next = '0;
    for (int k = 1; k <= NT; k++) begin
      if (k <= NA) pa_next = pa_next + (x1 >> (8*k));
      else pb_next = pb_next + (x1 >> (8*k));
    end
    r_full = x3 - (q3 << 8) + q3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= acc[ACC_W-1];
      x1   <= (acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc)) + ACC_W'(127);
      x2   <= x1;
      neg2 <= neg1;
      pa   <= pa_next;
      pb   <= pb_next;
      x3   <= x2;
      neg3 <= neg2;
      q3   <= pa + pb;
      neg4 <= neg3;
      q4   <= q3;
      r4   <= r_full[R_W-1:0];
    end
  end

  always_comb begin
    corr_p = (R_W+10)'({1'b0, r4} + 1'b1) * (R_W+10)'(257);
    q      = q4 + ACC_W'(corr_p[R_W+9:16]);
    sq     = neg4 ? -$signed(q) : $signed(q);
    if (sq > ACC_W'(32'sh7fffffff)) res = 32'sh7fffffff;
    else if (sq < -ACC_W'(33'sh080000000)) res = 32'sh80000000;
    else res = sq[31:0];
  end

endmodule

/* sv/lbs_back.sv */
// Back part: bone matrix table, transform and blend pipeline, output register.
module lbs_back (
  input  logic                              clk,
  input  logic                              rst,
  input  lbs_pkg::item_t                    head,
  input  logic                              empty,
  output logic                              pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lbs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser
);
  import lbs_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic [31:0] mem [ELEMS][MAX_BONES];
  logic [31:0] rd  [ELEMS];

  logic        adv, issue, beat;
  logic [1:0]  k;
  logic [BONE_W-1:0] cur_bone;

  logic        v1, v2, v3, v4, v5;
  logic        first1, first2, first3, first4;
  logic        last1, last2, last3, last4;
  logic        bad1, bad2, bad3, bad4, bad5;
  logic        zero1;
  logic [WGT_W-1:0] w1, w2, w3;
  logic [2:0][31:0] pos1;

  logic signed [PROD_W-1:0] p2 [3][3];
  logic signed [31:0]       m3_2 [3];
  logic signed [T_W-1:0]    t3 [3];
  logic signed [T_W-1:0]    t_next [3];
  logic signed [SUM_W-1:0]  s_sum [3];
  logic signed [WP_W-1:0]   wp4 [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [ACC_W-1:0]  accsum [3];
  logic signed [ACC_W-1:0]  a5 [3];
  logic signed [31:0]       res [3];
  logic [3:0]               vd;
  logic [3:0]               badd;

  assign adv      = !m_axis_tvalid || m_axis_tready;
  assign issue    = adv && !empty;
  assign beat     = issue && head.skin;
  assign pop      = issue && (!head.skin || k == head.last_k);
  assign cur_bone = head.bone[k];

  always_ff @(posedge clk) begin
    if (rst) k <= '0;
    else if (beat) k <= (k == head.last_k) ? 2'd0 : k + 2'd1;
  end

  // One bone row is read per beat; a load beat writes a single element.
  always_ff @(posedge clk) begin
    if (issue && !head.skin && 7'(head.slot) < 7'(MAX_BONES) && head.elem < ELEM_W'(ELEMS))
      mem[head.elem][head.slot[ADDR_W-1:0]] <= head.value;
    if (adv) begin
      for (int e = 0; e < ELEMS; e++) rd[e] <= mem[e][cur_bone[ADDR_W-1:0]];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_sum[c]  = SUM_W'(p2[0][c]) + SUM_W'(p2[1][c]) + SUM_W'(p2[2][c]) + HALF;
      t_next[c] = T_W'(s_sum[c] >>> FRAC_BITS) + T_W'(m3_2[c]);
      accsum[c] = (first4 ? ACC_W'(0) : acc[c]) + ACC_W'(wp4[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first1 <= (k == 2'd0);
      last1  <= (k == head.last_k);
      zero1  <= (cur_bone >= BONE_W'(MAX_BONES));
      w1     <= head.wgt[k];
      pos1   <= head.pos;
      bad1   <= head.bad;

      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          p2[r][c] <= $signed(pos1[r]) * (zero1 ? 32'sd0 : $signed(rd[r*3+c]));
      for (int c = 0; c < 3; c++) m3_2[c] <= zero1 ? 32'sd0 : $signed(rd[9+c]);
      first2 <= first1; last2 <= last1; w2 <= w1; bad2 <= bad1;

      for (int c = 0; c < 3; c++) t3[c] <= t_next[c];
      first3 <= first2; last3 <= last2; w3 <= w2; bad3 <= bad2;

      for (int c = 0; c < 3; c++) wp4[c] <= $signed(w3) * t3[c];
      first4 <= first3; last4 <= last3; bad4 <= bad3;

      if (v4) begin
        for (int c = 0; c < 3; c++) acc[c] <= accsum[c];
      end
      for (int c = 0; c < 3; c++) a5[c] <= accsum[c];
      bad5 <= bad4;
      badd <= {badd[2:0], bad5};
      m_axis_tdata <= {res[2], res[1], res[0]};
      m_axis_tuser <= badd[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      vd <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= beat;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4 && last4;
      vd <= {vd[2:0], v5};
      m_axis_tvalid <= vd[3];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    lbs_div255 u_div (
      .clk (clk),
      .en  (adv),
      .acc (a5[c]),
      .res (res[c])
    );
  end

endmodule

/* sv/linear_blend_vertex_skinning.sv */
// Top level of the linear blend vertex skinner for up to four bones per vertex.
// A vertex beat passes the queue, the transform and blend pipeline, the divide by
// 255 and the output register; it reads the matrix table once per blended bone.
// Throughput: one load beat per cycle while the queue is not full; a vertex holds the
// matrix table read port while each of its blended bones is read in turn.
// Reset clears the queue, the pipeline valids and the configuration registers; the
// matrix table is not cleared.
module linear_blend_vertex_skinning (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // bone_slot, element_index, element_value, pos_x, pos_y, pos_z, bone_bytes,
  // weight_bytes, zero pad
  input  logic [lbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                               s_axis_tuser,   // cmd
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // out_x, out_y, out_z
  output logic                               m_axis_tuser,   // bad_bone
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [6:0]                         cfg_data
);
  import lbs_pkg::*;

  logic  push, full, pop, empty;
  item_t push_item, head;

  lbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .push_item     (push_item),
    .q_full        (full)
  );

  lbs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  lbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* sv/lbs_checker.sv */
// Port-level checks for the vertex skinner, bound to the top level.
module lbs_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lbs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import lbs_pkg::*;

  logic [7:0] pend;
  logic       in_skin, out_beat;

  assign in_skin  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SKIN);
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Vertex beats accepted but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) pend <= '0;
    else if (in_skin && !out_beat) pend <= pend + 1'b1;
    else if (out_beat && !in_skin) pend <= pend - 1'b1;
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pend != 8'd0)
    else $error("result beat without a pending vertex");

endmodule

bind linear_blend_vertex_skinning lbs_port_checks u_lbs_port_checks (.*);

/* bench/lbs_checker.sv */
// Checker for the vertex skinner: mirrors the matrix table and registers, predicts and compares.
module lbs_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [lbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [lbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [6:0]                     cfg_data,
  output int                             errors,
  output int                             pending
);
  import lbs_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        bad;
  } skinned_t;

  logic signed [31:0] mats [MAX_BONES*ELEMS];
  logic [2:0] bones_per_vertex;
  logic [6:0] bone_count;
  skinned_t skinned_q[$];

  // One coordinate of one bone transform, rounded to nearest at the binary point.
  function automatic longint bone_xform(int b, int c, longint pos[3]);
    longint m[4];
    longint hi, lo, p, h, t;
    hi = 0;
    lo = 0;
    for (int r = 0; r < 4; r++)
      m[r] = (b < MAX_BONES) ? longint'(mats[b*ELEMS + r*3 + c]) : 0;
    for (int r = 0; r < 3; r++) begin
      p = pos[r] * m[r];
      h = p >>> FRAC_BITS;
      hi += h;
      lo += p - (h <<< FRAC_BITS);
    end
    t = hi + m[3] + (lo >> FRAC_BITS);
    if ((lo & ((64'sd1 << FRAC_BITS) - 1)) >= (64'sd1 << (FRAC_BITS - 1)))
      t += 1;
    return t;
  endfunction

  function automatic skinned_t skin_vertex(logic [IN_DATA_W-1:0] d);
    longint pos[3];
    longint w[4];
    int bone[4];
    int n;
    longint acc, v, rest;
    logic [31:0] o[3];
    skinned_t r;
    pos[0] = longint'($signed(d[73:42]));
    pos[1] = longint'($signed(d[105:74]));
    pos[2] = longint'($signed(d[137:106]));
    n = bones_per_vertex;
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    for (int k = 0; k < 4; k++)
      bone[k] = d[138 + 8*k +: 8] / 3;
    if (n == 2) begin
      w[0] = 255 - d[177:170];
      w[1] = d[177:170];
    end else if (n > 2) begin
      rest = 255;
      for (int k = 0; k < n - 1; k++) begin
        w[k] = d[170 + 8*k +: 8];
        rest -= w[k];
      end
      w[n-1] = rest;
    end
    r.bad = 1'b0;
    for (int k = 0; k < n; k++)
      if (bone[k] >= bone_count || bone[k] >= MAX_BONES) r.bad = 1'b1;
    for (int c = 0; c < 3; c++) begin
      if (n == 1) begin
        v = bone_xform(bone[0], c, pos);
      end else begin
        acc = 0;
        for (int k = 0; k < n; k++)
          acc += w[k] * bone_xform(bone[k], c, pos);
        v = (acc >= 0) ? (acc + 127) / 255 : -((-acc + 127) / 255);
      end
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      o[c] = v[31:0];
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    return r;
  endfunction

  initial begin
    foreach (mats[i]) mats[i] = '0;
  end

  always @(posedge clk) begin
    skinned_t e;
    if (rst) begin
      bones_per_vertex <= 3'd4;
      bone_count <= 7'd64;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BPV) bones_per_vertex <= cfg_data[2:0];
        else bone_count <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_SKIN)
          skinned_q.push_back(skin_vertex(s_axis_tdata));
        else if (s_axis_tdata[9:6] < ELEMS)
          mats[s_axis_tdata[5:0]*ELEMS + s_axis_tdata[9:6]] = s_axis_tdata[41:10];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (skinned_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          e = skinned_q.pop_front();
          if (m_axis_tdata !== {e.z, e.y, e.x} || m_axis_tuser !== e.bad) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected x=%h y=%h z=%h bad=%b, got x=%h y=%h z=%h bad=%b",
                       e.x, e.y, e.z, e.bad, m_axis_tdata[31:0], m_axis_tdata[63:32],
                       m_axis_tdata[95:64], m_axis_tuser);
          end
        end
      end
    end
    pending = skinned_q.size();
  end
endmodule

/* bench/linear_blend_vertex_skinning_tb.sv */
// Stimulus and verdict for the vertex skinner testbench.
module linear_blend_vertex_skinning_tb;
  import lbs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = CMD_LOAD;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_BPV;
  logic [6:0] cfg_data = '0;
  int errors, pending, quiet_cycles;
  logic calm = 1'b0;

  linear_blend_vertex_skinning DUT (.*);

  lbs_checker u_checker (.*);

  always #10 clk = ~clk;

  always @(negedge clk)
    m_axis_tready <= calm || ($urandom_range(99) >= 18);

  // Watchdog: any accepted beat restarts the count.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("linear_blend_vertex_skinning verification failed");
      $finish;
    end
  end

  task automatic send_beat(logic cmd, logic [IN_DATA_W-1:0] d);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 18) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic load_elem(int slot, int el, logic [31:0] v);
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    d[IN_DATA_W-1:194] = '0;
    d[5:0] = 6'(slot);
    d[9:6] = 4'(el);
    d[41:10] = v;
    send_beat(CMD_LOAD, d);
  endtask

  task automatic skin(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [31:0] bones, logic [23:0] wts);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[9:0] = 10'($urandom);
    d[41:10] = $urandom;
    d[73:42] = x;
    d[105:74] = y;
    d[137:106] = z;
    d[169:138] = bones;
    d[193:170] = wts;
    send_beat(CMD_SKIN, d);
  endtask

  task automatic cfg_write(logic idx, logic [6:0] v);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1 << 23)) - (1 << 22));
    endcase
  endfunction

  function automatic logic [31:0] rand_elem();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
  endfunction

  // Bytes pick bones 0 to 5 and the top four, which the fill loads; bytes of 192 and up
  // name bones past the table, which read as zero.
  function automatic logic [7:0] rand_bone_byte();
    case ($urandom_range(2))
      0: return 8'(3 * $urandom_range(5) + $urandom_range(2));
      1: return 8'(3 * $urandom_range(MAX_BONES - 1, MAX_BONES - 4) + $urandom_range(2));
      default: return 8'($urandom_range(255, 192));
    endcase
  endfunction

  initial begin
    logic [2:0] bpv_set [8] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd7, 3'd0, 3'd5, 3'd4};
    logic [6:0] bcnt_set [8] = '{7'd64, 7'd64, 7'd1, 7'd30, 7'd127, 7'd0, 7'd64, 7'd85};
    logic [31:0] bones;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every bone that a vertex may pick so that no read hits an unwritten entry.
    // Bone 0 is identity, bone 1 all maximum, bone 2 all minimum.
    for (int b = 0; b < MAX_BONES; b++)
      if (b < 6 || b >= MAX_BONES - 4)
        for (int e = 0; e < ELEMS; e++)
          case (b)
            0: load_elem(b, e, (e == 0 || e == 4 || e == 8) ? 32'h00010000 : 32'h0);
            1: load_elem(b, e, 32'h7fffffff);
            2: load_elem(b, e, 32'h80000000);
            default: load_elem(b, e, rand_elem());
          endcase

    // Directed vertices under the reset setting of four bones.
    skin(32'h00012345, 32'hfffe0000, 32'h7fffffff, 32'h0, 24'h0);
    skin(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h03030303, 24'h0);
    skin(32'h80000000, 32'h80000000, 32'h80000000, 32'h06060606, 24'h0);
    skin(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h06030603, 24'hffffff);
    skin(32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff, 24'h00ff00);
    skin(32'hffffffff, 32'h00000000, 32'h00010000, 32'hbe050402, 24'h807f01);
    skin(32'h00010000, 32'h00020000, 32'h00030000, 32'hbfbdbcbb, 24'hffff00);
    load_elem(3, 12, $urandom);
    load_elem(4, 15, $urandom);
    skin(32'h00010000, 32'h00010000, 32'h00010000, 32'h0c0b0a09, 24'h402010);

    foreach (bpv_set[p]) begin
      cfg_write(CFG_BPV, bpv_set[p]);
      cfg_write(CFG_BCNT, bcnt_set[p]);
      calm = (p == 3);
      for (int i = 0; i < 35; i++) begin
        if ($urandom_range(99) < 25) begin
          load_elem($urandom_range(63), $urandom_range(9) == 0 ? $urandom_range(15) :
                    $urandom_range(11), rand_elem());
        end else begin
          for (int k = 0; k < 4; k++) bones[8*k +: 8] = rand_bone_byte();
          skin(rand_coord(), rand_coord(), rand_coord(), bones, 24'($urandom));
        end
      end
      calm = 1'b0;
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("linear_blend_vertex_skinning verification clean");
    else
      $display("linear_blend_vertex_skinning verification failed");
    $finish;
  end
endmodule

/* sim.f */
sv/lbs_pkg.sv
sv/lbs_fifo.sv
sv/lbs_front.sv
sv/lbs_div255.sv
sv/lbs_back.sv
sv/linear_blend_vertex_skinning.sv
sv/lbs_checker.sv
bench/lbs_checker.sv
bench/linear_blend_vertex_skinning_tb.sv
